// ----- sv/atl_pkg.sv -----
`timescale 1ns / 1ps

package atl_pkg;

	localparam int POSITION_BITS_DEF = 16;
	localparam int FIFO_DEPTH        = 4;

	localparam logic [15:0] LINE_MAX  = 16'hFFFF;
	localparam logic [15:0] FIELD_MAX = 16'hFFFF;

	// source bytes with a meaning of their own
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef enum logic [2:0] {
		KIND_END   = 3'd0,
		KIND_ERROR = 3'd1,
		KIND_INT   = 3'd2,
		KIND_PLUS  = 3'd3,
		KIND_MINUS = 3'd4,
		KIND_STAR  = 3'd5,
		KIND_SLASH = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_NUMBER  = 3'd1,
		MODE_SLASH   = 3'd2,
		MODE_COMMENT = 3'd3,
		MODE_SKIP    = 3'd4
	} mode_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] start;
		logic [15:0] length;
		logic [15:0] line;
		logic        last;
	} tok_t;

	typedef struct packed {
		logic a;
		logic b;
	} push_t;

endpackage

// ----- sv/atl_scan.sv -----
`timescale 1ns / 1ps

module atl_scan #(
	parameter int POSITION_BITS = atl_pkg::POSITION_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic [7:0]    char_byte,
	output atl_pkg::push_t push,
	output atl_pkg::tok_t  tok_a,
	output atl_pkg::tok_t  tok_b
);
	import atl_pkg::*;

	localparam int PB = POSITION_BITS;
	localparam int W  = (PB > 16) ? PB : 16;

	mode_t           mode_q;
	mode_t           mode_d;
	logic [PB-1:0]   pos_q;
	logic [PB-1:0]   begin_q;
	logic [15:0]     line_q;

	logic [PB-1:0]   pos_next;
	logic            digit;

	// what a byte does when no token is open
	mode_t           idle_mode;
	logic            idle_emit;
	kind_t           idle_kind;
	logic            idle_begin;
	logic            idle_bump;
	logic            idle_restart;

	logic            do_idle;
	logic            begin_load;
	logic            bump;
	logic            restart;

	logic            close;
	kind_t           close_kind;
	logic [PB-1:0]   close_len;
	logic            side_emit;
	kind_t           side_kind;
	tok_t            close_tok;
	tok_t            side_tok;

	function automatic logic [15:0] clamp_f(input logic [PB-1:0] v);
		logic [W-1:0] e;
		e = W'(v);
		clamp_f = (e > W'(FIELD_MAX)) ? FIELD_MAX : e[15:0];
	endfunction

	assign pos_next = (pos_q == {PB{1'b1}}) ? pos_q : pos_q + PB'(1);
	assign digit    = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);

	always_comb begin
		idle_mode    = MODE_IDLE;
		idle_emit    = 1'b0;
		idle_kind    = KIND_END;
		idle_begin   = 1'b0;
		idle_bump    = 1'b0;
		idle_restart = 1'b0;
		if (digit) begin
			idle_mode  = MODE_NUMBER;
			idle_begin = 1'b1;
		end else begin
			case (char_byte)
				CH_SPACE, CH_TAB, CH_CR, CH_VT: begin
				end
				CH_LF: begin
					idle_bump = 1'b1;
				end
				CH_PLUS: begin
					idle_emit = 1'b1;
					idle_kind = KIND_PLUS;
				end
				CH_MINUS: begin
					idle_emit = 1'b1;
					idle_kind = KIND_MINUS;
				end
				CH_STAR: begin
					idle_emit = 1'b1;
					idle_kind = KIND_STAR;
				end
				CH_SLASH: begin
					idle_mode  = MODE_SLASH;
					idle_begin = 1'b1;
				end
				CH_NUL: begin
					idle_emit    = 1'b1;
					idle_kind    = KIND_END;
					idle_restart = 1'b1;
				end
				default: begin
					idle_emit = 1'b1;
					idle_kind = KIND_ERROR;
					idle_mode = MODE_SKIP;
				end
			endcase
		end
	end

	// next state
	always_comb begin
		mode_d     = mode_q;
		do_idle    = 1'b0;
		begin_load = 1'b0;
		bump       = 1'b0;
		restart    = 1'b0;
		case (mode_q)
			MODE_NUMBER: begin
				if (!digit) begin
					do_idle = 1'b1;
				end
			end
			MODE_SLASH: begin
				if (char_byte == CH_SLASH) begin
					mode_d = MODE_COMMENT;
				end else begin
					do_idle = 1'b1;
				end
			end
			MODE_COMMENT: begin
				if (char_byte == CH_LF) begin
					bump   = 1'b1;
					mode_d = MODE_IDLE;
				end else if (char_byte == CH_NUL) begin
					do_idle = 1'b1;
				end
			end
			MODE_SKIP: begin
				if (char_byte == CH_NUL) begin
					restart = 1'b1;
					mode_d  = MODE_IDLE;
				end
			end
			default: begin
				do_idle = 1'b1;
			end
		endcase
		if (do_idle) begin
			mode_d     = idle_mode;
			begin_load = idle_begin;
			bump       = idle_bump;
			restart    = idle_restart;
		end
	end

	// tokens: an open token closed by this byte goes first
	always_comb begin
		close      = 1'b0;
		close_kind = KIND_INT;
		close_len  = pos_q - begin_q;
		side_emit  = 1'b0;
		side_kind  = idle_kind;
		case (mode_q)
			MODE_NUMBER: begin
				close = !digit;
			end
			MODE_SLASH: begin
				close      = (char_byte != CH_SLASH);
				close_kind = KIND_SLASH;
				close_len  = PB'(1);
			end
			default: begin
			end
		endcase
		if (mode_q == MODE_SKIP) begin
			side_emit = (char_byte == CH_NUL);
			side_kind = KIND_END;
		end else begin
			side_emit = do_idle && idle_emit;
		end

		close_tok.kind   = close_kind;
		close_tok.start  = clamp_f(begin_q);
		close_tok.length = clamp_f(close_len);
		close_tok.line   = line_q;
		close_tok.last   = !side_emit;

		side_tok.kind    = side_kind;
		side_tok.start   = clamp_f(pos_q);
		side_tok.length  = 16'd1;
		side_tok.line    = line_q;
		side_tok.last    = 1'b1;

		if (close) begin
			tok_a  = close_tok;
			tok_b  = side_tok;
			push.a = step;
			push.b = step && side_emit;
		end else begin
			tok_a  = side_tok;
			tok_b  = side_tok;
			push.a = step && side_emit;
			push.b = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			pos_q   <= '0;
			begin_q <= '0;
			line_q  <= 16'd1;
		end else if (step) begin
			if (restart) begin
				mode_q  <= MODE_IDLE;
				pos_q   <= '0;
				begin_q <= '0;
				line_q  <= 16'd1;
			end else begin
				mode_q <= mode_d;
				pos_q  <= pos_next;
				if (begin_load) begin
					begin_q <= pos_q;
				end
				if (bump && (line_q != LINE_MAX)) begin
					line_q <= line_q + 16'd1;
				end
			end
		end
	end

endmodule

// ----- sv/atl_fifo.sv -----
`timescale 1ns / 1ps

module atl_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  atl_pkg::push_t push,
	input  atl_pkg::tok_t  tok_a,
	input  atl_pkg::tok_t  tok_b,
	input  logic           pop,
	output atl_pkg::tok_t  head,
	output logic           not_empty,
	output logic           room2
);
	import atl_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	tok_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] wr_ptr_b;

	assign wr_ptr_b  = wr_ptr_q + PTR_W'(1);
	assign head      = mem_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign room2     = (count_q <= CNT_W'(FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.a) begin
			mem_q[wr_ptr_q] <= tok_a;
		end
		if (push.b) begin
			mem_q[wr_ptr_b] <= tok_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.a) + PTR_W'(push.b);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			count_q  <= count_q + CNT_W'(push.a) + CNT_W'(push.b) - CNT_W'(pop);
		end
	end

endmodule

// ----- sv/arithmetic_token_lexer.sv -----
`timescale 1ns / 1ps
// path: a byte is registered in the input stage, and its tokens are then
// written into the token queue, whose head drives the token port
// throughput: one byte per cycle while the token queue has room for two tokens,
// else char_stall holds the byte; a byte that closes an open token and emits
// another puts both into a four-entry token queue behind the single token port
// reset: arst_n clears the queue, the input stage and the scan state (line 1)

module arithmetic_token_lexer #(
	parameter int POSITION_BITS = atl_pkg::POSITION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_stall,
	input  logic [7:0]  char_byte,
	output logic        token_valid,
	input  logic        token_stall,
	output logic [2:0]  token_kind,
	output logic [15:0] token_start,
	output logic [15:0] token_length,
	output logic [15:0] token_line,
	output logic        last_of_run
);
	import atl_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       step;
	logic       room2;
	push_t      push;
	tok_t       tok_a;
	tok_t       tok_b;
	tok_t       head;

	assign step       = valid_s1 && room2;
	assign char_stall = valid_s1 && !room2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!char_stall) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			byte_s1 <= char_byte;
		end
	end

	atl_scan #(
		.POSITION_BITS(POSITION_BITS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.char_byte(byte_s1),
		.push     (push),
		.tok_a    (tok_a),
		.tok_b    (tok_b)
	);

	atl_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.tok_a    (tok_a),
		.tok_b    (tok_b),
		.pop      (token_valid && !token_stall),
		.head     (head),
		.not_empty(token_valid),
		.room2    (room2)
	);

	assign token_kind   = head.kind;
	assign token_start  = head.start;
	assign token_length = head.length;
	assign token_line   = head.line;
	assign last_of_run  = head.last;

endmodule

// ----- sv/atl_checker.sv -----
`timescale 1ns / 1ps

module atl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        token_valid,
	input logic        token_stall,
	input logic [2:0]  token_kind,
	input logic [15:0] token_start,
	input logic [15:0] token_length,
	input logic [15:0] token_line,
	input logic        last_of_run
);
	import atl_pkg::*;

	// a stalled item stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_stall |=> token_valid && $stable(token_kind)
			&& $stable(token_start) && $stable(token_length)
			&& $stable(token_line) && $stable(last_of_run))
		else $error("token item changed while stalled");

	// end and error tokens always close the run of their byte
	assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && (token_kind == KIND_END || token_kind == KIND_ERROR)
			|-> last_of_run)
		else $error("end or error token not last of run");

	// only a token closed by the next byte can be followed by another
	assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && !last_of_run
			|-> token_kind == KIND_INT || token_kind == KIND_SLASH)
		else $error("leading token of a pair is not integer or slash");

	// operator, end and error tokens span a single byte
	assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_kind != KIND_INT |-> token_length == 16'd1)
		else $error("single-byte token with wrong length");

endmodule

bind arithmetic_token_lexer atl_checker u_atl_checker (.*);

// ----- tb/sv/token_watch.sv -----
`timescale 1ns / 1ps

module token_watch #(
	parameter int POS_BITS = atl_pkg::POSITION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	input  logic        char_stall,
	input  logic [7:0]  char_byte,
	input  logic        token_valid,
	input  logic        token_stall,
	input  logic [2:0]  token_kind,
	input  logic [15:0] token_start,
	input  logic [15:0] token_length,
	input  logic [15:0] token_line,
	input  logic        last_of_run,
	output int          mismatches,
	output int          waiting
);
	import atl_pkg::*;

	localparam longint unsigned POS_LIMIT = (64'd1 << POS_BITS) - 64'd1;

	mode_t           scan;
	longint unsigned next_pos;
	longint unsigned tok_begin;
	logic [15:0]     line_no;
	tok_t            expected_tokens[$];

	function automatic logic [15:0] clamp_field(longint unsigned v);
		return (v > 64'(FIELD_MAX)) ? FIELD_MAX : v[15:0];
	endfunction

	task automatic expect_token(kind_t kind, longint unsigned start, longint unsigned len);
		tok_t t;
		t.kind   = kind;
		t.start  = clamp_field(start);
		t.length = clamp_field(len);
		t.line   = line_no;
		t.last   = 1'b0;
		expected_tokens.push_back(t);
	endtask

	task automatic clear_scan();
		scan      = MODE_IDLE;
		next_pos  = 0;
		tok_begin = 0;
		line_no   = 16'd1;
	endtask

	task automatic count_line();
		if (line_no < LINE_MAX) begin
			line_no = line_no + 16'd1;
		end
	endtask

	// byte seen with no token open
	task automatic open_token(logic [7:0] b, longint unsigned pos);
		scan = MODE_IDLE;
		if (b >= CH_ZERO && b <= CH_NINE) begin
			scan      = MODE_NUMBER;
			tok_begin = pos;
		end else begin
			case (b)
				CH_SPACE, CH_TAB, CH_CR, CH_VT: ;
				CH_LF: count_line();
				CH_PLUS: expect_token(KIND_PLUS, pos, 1);
				CH_MINUS: expect_token(KIND_MINUS, pos, 1);
				CH_STAR: expect_token(KIND_STAR, pos, 1);
				CH_SLASH: begin
					scan      = MODE_SLASH;
					tok_begin = pos;
				end
				CH_NUL: begin
					expect_token(KIND_END, pos, 1);
					clear_scan();
				end
				default: begin
					expect_token(KIND_ERROR, pos, 1);
					scan = MODE_SKIP;
				end
			endcase
		end
	endtask

	task automatic lex_byte(logic [7:0] b);
		longint unsigned pos;
		int              queued;
		pos    = next_pos;
		queued = expected_tokens.size();
		if (next_pos < POS_LIMIT) begin
			next_pos = next_pos + 1;
		end
		case (scan)
			MODE_NUMBER: begin
				if (!(b >= CH_ZERO && b <= CH_NINE)) begin
					expect_token(KIND_INT, tok_begin, pos - tok_begin);
					open_token(b, pos);
				end
			end
			MODE_SLASH: begin
				if (b == CH_SLASH) begin
					scan = MODE_COMMENT;
				end else begin
					expect_token(KIND_SLASH, tok_begin, 1);
					open_token(b, pos);
				end
			end
			MODE_COMMENT: begin
				if (b == CH_LF) begin
					count_line();
					scan = MODE_IDLE;
				end else if (b == CH_NUL) begin
					open_token(b, pos);
				end
			end
			MODE_SKIP: begin
				if (b == CH_NUL) begin
					expect_token(KIND_END, pos, 1);
					clear_scan();
				end
			end
			default: open_token(b, pos);
		endcase
		if (expected_tokens.size() > queued) begin
			expected_tokens[expected_tokens.size() - 1].last = 1'b1;
		end
	endtask

	task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_token();
		tok_t want;
		if (expected_tokens.size() == 0) begin
			$display("%0t: token_kind expected none, got %0d (start %0d)",
				$time, token_kind, token_start);
			mismatches++;
		end else begin
			want = expected_tokens.pop_front();
			compare_field("token_kind", 16'(want.kind), 16'(token_kind));
			compare_field("token_start", want.start, token_start);
			compare_field("token_length", want.length, token_length);
			compare_field("token_line", want.line, token_line);
			compare_field("last_of_run", 16'(want.last), 16'(last_of_run));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_scan();
			expected_tokens.delete();
			waiting = 0;
		end else begin
			// a token never leaves in the edge that takes its byte
			if (token_valid && !token_stall) begin
				check_token();
			end
			if (char_valid && !char_stall) begin
				lex_byte(char_byte);
			end
			waiting = expected_tokens.size();
		end
	end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import atl_pkg::*;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        char_valid  = 1'b0;
	logic [7:0]  char_byte   = 8'h00;
	logic        token_stall = 1'b0;
	logic        char_stall;
	logic        token_valid;
	logic [2:0]  token_kind;
	logic [15:0] token_start;
	logic [15:0] token_length;
	logic [15:0] token_line;
	logic        last_of_run;
	int          mismatches;
	int          waiting;

	int         gap_pct    = 0;
	int         stall_pct  = 0;
	int         sent       = 0;
	int         skipped    = 0;
	logic [7:0] src_bytes[$];

	int gap_tab[4]   = '{0, 65, 0, 29};
	int stall_tab[4] = '{0, 0, 65, 29};

	arithmetic_token_lexer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.char_byte    (char_byte),
		.token_valid  (token_valid),
		.token_stall  (token_stall),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_length (token_length),
		.token_line   (token_line),
		.last_of_run  (last_of_run)
	);

	token_watch watch (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.char_byte    (char_byte),
		.token_valid  (token_valid),
		.token_stall  (token_stall),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_length (token_length),
		.token_line   (token_line),
		.last_of_run  (last_of_run),
		.mismatches   (mismatches),
		.waiting      (waiting)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		token_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic send_byte(logic [7:0] b);
		while ($urandom_range(99) < gap_pct) begin
			char_valid <= 1'b0;
			@(posedge clk);
		end
		char_valid <= 1'b1;
		char_byte  <= b;
		do @(posedge clk); while (char_stall);
		sent++;
	endtask

	task automatic send_source();
		foreach (src_bytes[i]) begin
			send_byte(src_bytes[i]);
		end
		src_bytes.delete();
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++) begin
			src_bytes.push_back(s[i]);
		end
	endtask

	task automatic add_number();
		repeat ($urandom_range(1, 5)) src_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
	endtask

	task automatic add_comment(bit closed);
		logic [7:0] b;
		src_bytes.push_back(CH_SLASH);
		src_bytes.push_back(CH_SLASH);
		repeat ($urandom_range(0, 4)) begin
			b = 8'($urandom_range(1, 255));
			src_bytes.push_back(b == CH_LF ? CH_SPACE : b);
		end
		if (closed) begin
			src_bytes.push_back(CH_LF);
		end
	endtask

	// expression text with random content, no end byte
	task automatic add_expression();
		logic [7:0] blanks[4];
		logic [7:0] ops[3];
		blanks = '{CH_SPACE, CH_TAB, CH_CR, CH_VT};
		ops    = '{CH_PLUS, CH_MINUS, CH_STAR};
		repeat ($urandom_range(1, 12)) begin
			case ($urandom_range(0, 9))
				0, 1, 2: add_number();
				3, 4: src_bytes.push_back(ops[$urandom_range(0, 2)]);
				5: src_bytes.push_back(CH_SLASH);
				6: src_bytes.push_back(blanks[$urandom_range(0, 3)]);
				7: src_bytes.push_back(CH_LF);
				8: add_comment(1'b1);
				default: src_bytes.push_back(CH_SPACE);
			endcase
		end
	endtask

	task automatic add_random_source();
		int pick;
		int tail;
		pick = $urandom_range(0, 99);
		if (pick < 75) begin
			add_expression();
			if ($urandom_range(0, 9) == 0) begin
				add_comment(1'b0);
			end
		end else if (pick < 88) begin
			// broken source: an unknown byte, then bytes the lexer skips
			add_expression();
			src_bytes.push_back({1'b1, 7'($urandom)});
			tail = $urandom_range(0, 5);
			repeat (tail) src_bytes.push_back(8'($urandom_range(1, 255)));
			skipped += tail;
		end else begin
			repeat ($urandom_range(1, 10)) src_bytes.push_back(8'($urandom_range(0, 255)));
		end
		src_bytes.push_back(CH_NUL);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every operator, blanks, a comment, an integer closed by the end byte
		add_text("90+1-2*3/");
		src_bytes.push_back(CH_SPACE);
		src_bytes.push_back(CH_TAB);
		src_bytes.push_back(CH_CR);
		src_bytes.push_back(CH_VT);
		add_text("4//");
		src_bytes.push_back(8'hFF);
		src_bytes.push_back(CH_LF);
		add_text("7");
		src_bytes.push_back(CH_NUL);
		// slash closed by the end byte, comment closed by the end byte
		add_text("/");
		src_bytes.push_back(CH_NUL);
		add_text("//");
		src_bytes.push_back(CH_NUL);
		// unknown byte, then a newline and a digit that are skipped
		src_bytes.push_back(8'h80);
		src_bytes.push_back(CH_LF);
		add_text("5");
		src_bytes.push_back(CH_NUL);
		src_bytes.push_back(CH_NUL);
		send_source();

		// a longer source over many lines with a long integer
		add_text("5");
		repeat (20) src_bytes.push_back(CH_LF);
		add_text("1234567890123456789+");
		repeat (3) src_bytes.push_back(CH_LF);
		add_text("//c");
		src_bytes.push_back(CH_LF);
		add_text("9/");
		src_bytes.push_back(CH_NUL);
		send_source();

		for (int ph = 0; ph < 4; ph++) begin
			int target;
			gap_pct   = gap_tab[ph];
			stall_pct = stall_tab[ph];
			target    = sent - skipped + 450;
			while (sent - skipped < target) begin
				add_random_source();
				send_source();
			end
		end
		char_valid <= 1'b0;

		for (int i = 0; i < 10000 && waiting != 0; i++) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (mismatches == 0 && waiting == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
sv/atl_pkg.sv
sv/atl_scan.sv
sv/atl_fifo.sv
sv/arithmetic_token_lexer.sv
sv/atl_checker.sv
tb/sv/token_watch.sv
tb/sv/testbench.sv
